### src/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg
// Shared types and constants for the response frame parser.
// ----------------------------------------------------------------------------
package mrfp_pkg;

    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_M      = 8'h4D;
    localparam logic [7:0] SYNC_ARROW  = 8'h3E;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TDATA_W = 40;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] command_id;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] payload_length;
        logic       checksum_ok;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t item;
    } push_t;

    typedef struct packed {
        logic    not_empty;
        result_t item;
    } head_t;

endpackage

### src/mrfp_front.sv
// ----------------------------------------------------------------------------
// mrfp_front
// Accepts received bytes, tracks the frame phase and builds result items.
// ----------------------------------------------------------------------------
module mrfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          rx_byte,
    output mrfp_pkg::push_t     push_out
);
    import mrfp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_M     = 3'd1,
        PH_ARROW = 3'd2,
        PH_LEN   = 3'd3,
        PH_CMD   = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6,
        PH_SPARE = 3'd7
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        command_next  = command_reg;
        xor_next      = xor_reg;
        push_out      = '0;
        push_out.item.command_id     = command_reg;
        push_out.item.payload_length = length_reg;
        if (in_accept) begin
            unique case (phase_reg)
                PH_M: begin
                    phase_next = (rx_byte == SYNC_M) ? PH_ARROW : PH_IDLE;
                end
                PH_ARROW: begin
                    phase_next = (rx_byte == SYNC_ARROW) ? PH_LEN : PH_IDLE;
                end
                PH_LEN: begin
                    length_next = rx_byte;
                    xor_next    = rx_byte;
                    phase_next  = PH_CMD;
                end
                PH_CMD: begin
                    command_next = rx_byte;
                    xor_next     = xor_reg ^ rx_byte;
                    phase_next   = (length_reg == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    push_out.push           = 1'b1;
                    push_out.item.kind      = KIND_PAYLOAD;
                    push_out.item.data_byte = rx_byte;
                    push_out.item.byte_index = count_reg;
                    xor_next   = xor_reg ^ rx_byte;
                    count_next = count_inc;
                    if (count_inc >= length_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    push_out.push             = 1'b1;
                    push_out.item.kind        = KIND_FRAME_END;
                    push_out.item.checksum_ok = (rx_byte == xor_reg);
                    phase_next = PH_IDLE;
                end
                PH_IDLE, PH_SPARE: begin
                    length_next  = 8'd0;
                    count_next   = 8'd0;
                    command_next = 8'd0;
                    xor_next     = 8'd0;
                    phase_next   = (rx_byte == SYNC_DOLLAR) ? PH_M : PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            length_reg  <= 8'd0;
            count_reg   <= 8'd0;
            command_reg <= 8'd0;
            xor_reg     <= 8'd0;
        end else begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            command_reg <= command_next;
            xor_reg     <= xor_next;
        end
    end

    // a zero-length frame never reaches the payload phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (length_reg != 8'd0))
        else $error("payload phase with zero length");

endmodule

### src/mrfp_queue.sv
// ----------------------------------------------------------------------------
// mrfp_queue
// Short result queue between the parser front and the output stage.
// ----------------------------------------------------------------------------
module mrfp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  mrfp_pkg::push_t    push_in,
    input  logic               pop,
    output mrfp_pkg::head_t    head,
    output logic               full
);
    import mrfp_pkg::*;

    result_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wptr_reg, wptr_next;
    logic [QPTR_W-1:0]    rptr_reg, rptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 do_pop;

    assign full           = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.not_empty = (count_reg != '0);
    assign head.item      = mem[rptr_reg];
    assign do_pop         = pop && head.not_empty;

    always_comb begin
        wptr_next  = push_in.push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push_in.push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_in.push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem[wptr_reg] <= push_in.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_in.push && full))
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    // occupancy agrees with the pointer distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != QCNT_W'(QUEUE_DEPTH)) |->
        (QPTR_W'(wptr_reg - rptr_reg) == QPTR_W'(count_reg)))
        else $error("queue pointers disagree with count");

endmodule

### src/mrfp_back.sv
// ----------------------------------------------------------------------------
// mrfp_back
// Output stage: takes results from the queue and holds the master transaction.
// ----------------------------------------------------------------------------
module mrfp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mrfp_pkg::head_t               head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mrfp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import mrfp_pkg::*;

    logic       valid_reg, valid_next;
    result_t    item_reg;

    assign pop = head.not_empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head.item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = item_reg.kind;
    assign m_tdata  = {7'd0,
                       item_reg.checksum_ok,
                       item_reg.payload_length,
                       item_reg.byte_index,
                       item_reg.data_byte,
                       item_reg.command_id};

    // a held result is never overwritten before it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!valid_reg || m_tready))
        else $error("output overwritten while stalled");

endmodule

### src/msp_v1_response_frame_parser.sv
// ----------------------------------------------------------------------------
// msp_v1_response_frame_parser
// Recognizes '$' 'M' '>' length command payload checksum response frames.
// ----------------------------------------------------------------------------
// One received byte is accepted per cycle while s_tready is high. Each payload
// byte yields a result transaction, and the checksum byte a frame-end
// transaction with the declared length and the checksum verdict. A four-entry
// result queue and an output register separate the input from the result
// channel, so input bytes keep flowing while results wait; s_tready drops only
// when the queue is full, which sets the rate under sustained back-pressure.
module msp_v1_response_frame_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // command_id, data_byte, byte_index, payload_length, checksum_ok, zero pad
    output logic [mrfp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser    // result_kind
);
    import mrfp_pkg::*;

    push_t  push_bus;
    head_t  head_bus;
    logic   full;
    logic   pop;

    assign s_tready = !full;

    mrfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_tvalid && s_tready),
        .rx_byte   (s_tdata),
        .push_out  (push_bus)
    );

    mrfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_in  (push_bus),
        .pop      (pop),
        .head     (head_bus),
        .full     (full)
    );

    mrfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_bus),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### tb/sv/msp_v1_response_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// msp_v1_response_frame_parser_tb
// Self-checking bench for the response frame parser. Bytes are sent one per
// transaction: a short directed table first, then randomized well-formed
// frames mixed with broken headers and line noise. A behavioral frame decoder
// predicts every payload and frame-end transaction, and the result stream is
// compared field by field in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module msp_v1_response_frame_parser_tb;
    import mrfp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WANT_M,
        PH_WANT_ARROW,
        PH_WANT_LEN,
        PH_WANT_CMD,
        PH_PAYLOAD,
        PH_WANT_CHECK
    } parse_phase_t;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        result_t    want;
    } directed_row_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int bytes_sent    = 0;

    result_t       expected_results[$];
    directed_row_t directed_rows[22];

    parse_phase_t frame_phase = PH_IDLE;
    logic [7:0]   frame_len   = 8'h00;
    logic [7:0]   frame_count = 8'h00;
    logic [7:0]   frame_cmd   = 8'h00;
    logic [7:0]   frame_xor   = 8'h00;

    always #5 aclk = ~aclk;

    msp_v1_response_frame_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic void parse_frame_byte(input logic [7:0] b, output bit produced,
                                             output result_t r);
        produced = 1'b0;
        r = '0;
        case (frame_phase)
            PH_WANT_M: begin
                frame_phase = (b == SYNC_M) ? PH_WANT_ARROW : PH_IDLE;
            end
            PH_WANT_ARROW: begin
                frame_phase = (b == SYNC_ARROW) ? PH_WANT_LEN : PH_IDLE;
            end
            PH_WANT_LEN: begin
                frame_len = b;
                frame_xor = b;
                frame_phase = PH_WANT_CMD;
            end
            PH_WANT_CMD: begin
                frame_cmd = b;
                frame_xor = frame_xor ^ b;
                frame_phase = (frame_len == 8'h00) ? PH_WANT_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                produced = 1'b1;
                r.kind = KIND_PAYLOAD;
                r.command_id = frame_cmd;
                r.data_byte = b;
                r.byte_index = frame_count;
                r.payload_length = frame_len;
                r.checksum_ok = 1'b0;
                frame_xor = frame_xor ^ b;
                frame_count = frame_count + 8'd1;
                if (frame_count >= frame_len) begin
                    frame_phase = PH_WANT_CHECK;
                end
            end
            PH_WANT_CHECK: begin
                produced = 1'b1;
                r.kind = KIND_FRAME_END;
                r.command_id = frame_cmd;
                r.payload_length = frame_len;
                r.checksum_ok = (b == frame_xor);
                frame_phase = PH_IDLE;
            end
            default: begin
                frame_len = 8'h00;
                frame_count = 8'h00;
                frame_cmd = 8'h00;
                frame_xor = 8'h00;
                frame_phase = (b == SYNC_DOLLAR) ? PH_WANT_M : PH_IDLE;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t want = '0);
        bit      produced;
        result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        parse_frame_byte(b, produced, r);
        if (typed) begin
            expected_results.push_back(want);
        end else if (produced) begin
            expected_results.push_back(r);
        end
        bytes_sent++;
    endtask

    task automatic send_frame(input bit break_header);
        int         len;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] b;
        if (break_header) begin
            send_byte(SYNC_DOLLAR);
            b = 8'($urandom);
            if ($urandom_range(1) == 0) begin
                if (b == SYNC_M) b = ~b;
            end else begin
                send_byte(SYNC_M);
                if (b == SYNC_ARROW) b = ~b;
            end
            send_byte(b);
            return;
        end
        len = ($urandom_range(39) == 0) ? 255 : $urandom_range(0, 16);
        cmd = 8'($urandom);
        sum = len[7:0] ^ cmd;
        send_byte(SYNC_DOLLAR);
        send_byte(SYNC_M);
        send_byte(SYNC_ARROW);
        send_byte(len[7:0]);
        send_byte(cmd);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            sum = sum ^ b;
            send_byte(b);
        end
        // one frame in four carries a random, mostly wrong checksum
        if ($urandom_range(3) == 0) begin
            sum = 8'($urandom);
        end
        send_byte(sum);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int n_bytes);
        int start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            case ($urandom_range(9))
                0: send_byte(8'($urandom));
                1: send_frame(1'b1);
                default: send_frame(1'b0);
            endcase
        end
        // hold off until the result stream has drained
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            // m_tdata: command_id, data_byte, byte_index, payload_length, checksum_ok
            got.kind = kind_t'(m_tuser);
            got.command_id = m_tdata[7:0];
            got.data_byte = m_tdata[15:8];
            got.byte_index = m_tdata[23:16];
            got.payload_length = m_tdata[31:24];
            got.checksum_ok = m_tdata[32];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: kind %0d cmd %h data %h idx %h len %h ok %0d",
                             got.kind, got.command_id, got.data_byte, got.byte_index,
                             got.payload_length, got.checksum_ok);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.command_id !== want.command_id
                        || got.data_byte !== want.data_byte
                        || got.byte_index !== want.byte_index
                        || got.payload_length !== want.payload_length
                        || got.checksum_ok !== want.checksum_ok) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind %0d cmd %h data %h idx %h len %h ok %0d",
                                 want.kind, want.command_id, want.data_byte, want.byte_index,
                                 want.payload_length, want.checksum_ok);
                        $display("          actual   kind %0d cmd %h data %h idx %h len %h ok %0d",
                                 got.kind, got.command_id, got.data_byte, got.byte_index,
                                 got.payload_length, got.checksum_ok);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        directed_rows = '{
            // noise while idle
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            // zero-length frame, command at its maximum, good checksum
            '{SYNC_DOLLAR, 1'b0, '0},
            '{SYNC_M, 1'b0, '0},
            '{SYNC_ARROW, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b1, '{KIND_FRAME_END, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1}},
            // broken header where M is due, then a stray M while idle
            '{SYNC_DOLLAR, 1'b0, '0},
            '{8'h58, 1'b0, '0},
            '{SYNC_M, 1'b0, '0},
            // broken header where the arrow is due, a dollar is not resynced
            '{SYNC_DOLLAR, 1'b0, '0},
            '{SYNC_M, 1'b0, '0},
            '{SYNC_DOLLAR, 1'b0, '0},
            // two-byte payload with a bad checksum
            '{SYNC_DOLLAR, 1'b0, '0},
            '{SYNC_M, 1'b0, '0},
            '{SYNC_ARROW, 1'b0, '0},
            '{8'h02, 1'b0, '0},
            '{8'h80, 1'b0, '0},
            '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'h80, 8'hFF, 8'h00, 8'h02, 1'b0}},
            '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'h80, 8'h00, 8'h01, 8'h02, 1'b0}},
            '{8'h00, 1'b1, '{KIND_FRAME_END, 8'h80, 8'h00, 8'h00, 8'h02, 1'b0}}
        };
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 7;
        recv_idle_pct = 88;
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        end
        run_phase(7, 88, 500);
        run_phase(88, 7, 500);
        run_phase(0, 0, 500);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
